/* sv/tnp_pkg.sv */
// ----------------------------------------------------------------------------
// tnp_pkg
// Shared types and constants for the telnet option parser: protocol bytes,
// token kinds, parser and control states, refusal codes.
// ----------------------------------------------------------------------------
package tnp_pkg;

   localparam int unsigned OptCount = 256;
   localparam int unsigned OptWidth = 8;
   localparam int unsigned PtrWidth = OptWidth + 1;

   localparam logic [7:0] BYTE_IAC  = 8'hFF;
   localparam logic [7:0] BYTE_DONT = 8'hFE;
   localparam logic [7:0] BYTE_DO   = 8'hFD;
   localparam logic [7:0] BYTE_WONT = 8'hFC;
   localparam logic [7:0] BYTE_WILL = 8'hFB;
   localparam logic [7:0] BYTE_SB   = 8'd250;
   localparam logic [7:0] BYTE_GA   = 8'd249;
   localparam logic [7:0] BYTE_BRK  = 8'd243;
   localparam logic [7:0] BYTE_NOP  = 8'd241;
   localparam logic [7:0] BYTE_SE   = 8'd240;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] BYTE_LF   = 8'h0A;

   localparam logic [7:0] VERB_DO   = 8'd0;
   localparam logic [7:0] VERB_DONT = 8'd1;
   localparam logic [7:0] VERB_WILL = 8'd2;
   localparam logic [7:0] VERB_WONT = 8'd3;

   typedef enum logic [2:0] {
      KIND_TEXT    = 3'd0,
      KIND_NEWLINE = 3'd1,
      KIND_COMMAND = 3'd2,
      KIND_NEGO    = 3'd3,
      KIND_SUBNEG  = 3'd4,
      KIND_REFUSAL = 3'd5,
      KIND_DONE    = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      REFUSAL_NONE = 2'd0,
      REFUSAL_WONT = 2'd1,
      REFUSAL_DONT = 2'd2
   } refusal_type;

   typedef enum logic [3:0] {
      PARSE_DATA    = 4'd0,
      PARSE_IAC     = 4'd1,
      PARSE_DO      = 4'd2,
      PARSE_DONT    = 4'd3,
      PARSE_WILL    = 4'd4,
      PARSE_WONT    = 4'd5,
      PARSE_SB      = 4'd6,
      PARSE_SB_DATA = 4'd7,
      PARSE_SINK    = 4'd8
   } parse_state_type;

   typedef enum logic [1:0] {
      CTL_CLEAR = 2'd0,
      CTL_IDLE  = 2'd1,
      CTL_READ  = 2'd2,
      CTL_CHECK = 2'd3
   } ctl_state_type;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [7:0]          code;
      logic [OptWidth-1:0] option;
   } token_type;

   typedef struct packed {
      logic                we;
      logic [OptWidth-1:0] addr;
      refusal_type         refusal;
   } store_wr_type;

   localparam logic [7:0] CODE_WONT = BYTE_WONT;
   localparam logic [7:0] CODE_DONT = BYTE_DONT;

endpackage

/* sv/telnet_option_parser.sv */
// ----------------------------------------------------------------------------
// telnet_option_parser
// Telnet byte stream to token converter with a per-option refusal store.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the refusal store and
// accepts no item during that pass. A data byte's token, if any, lands in
// the output register, and the next byte is taken in the following cycle
// as long as the output side keeps up. A pull walks the refusal memory
// from the scan pointer, reading each entry and then checking the
// registered data, until a refusal is found or the last entry is checked;
// with the pointer past the end (store known empty) it answers without a scan.
// ----------------------------------------------------------------------------
module telnet_option_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_code,
   output logic [7:0] rsp_option
);

   tnp_pkg::ctl_state_type ctl_ff, ctl_in;
   logic [tnp_pkg::PtrWidth-1:0] ptr_ff, ptr_in;
   logic [tnp_pkg::OptWidth-1:0] clr_ff, clr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tnp_pkg::kind_type            rsp_kind_ff, rsp_kind_in;
   logic [7:0]                   rsp_code_ff, rsp_code_in;
   logic [7:0]                   rsp_option_ff, rsp_option_in;

   logic                   req_fire;
   logic                   slot_free;
   logic                   load;
   logic                   rd_en;
   tnp_pkg::token_type     dec_token;
   tnp_pkg::store_wr_type  dec_wr;
   tnp_pkg::store_wr_type  mem_wr;
   tnp_pkg::refusal_type   rd_data;
   tnp_pkg::token_type     tok;
   logic                   found;
   logic                   last_entry;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (ctl_ff == tnp_pkg::CTL_IDLE) && slot_free;
   assign req_fire   = req_valid && req_ready;
   assign found      = (rd_data != tnp_pkg::REFUSAL_NONE);
   assign last_entry = (ptr_ff[tnp_pkg::OptWidth-1:0] == {tnp_pkg::OptWidth{1'b1}});

   tnp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire && !req_action),
      .data_byte (req_data_byte),
      .token     (dec_token),
      .store_wr  (dec_wr)
   );

   tnp_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[tnp_pkg::OptWidth-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         tnp_pkg::CTL_CLEAR: begin
            if (clr_ff == {tnp_pkg::OptWidth{1'b1}}) ctl_in = tnp_pkg::CTL_IDLE;
         end
         tnp_pkg::CTL_IDLE: begin
            if (req_fire && req_action && !ptr_ff[tnp_pkg::OptWidth]) ctl_in = tnp_pkg::CTL_READ;
         end
         tnp_pkg::CTL_READ: ctl_in = tnp_pkg::CTL_CHECK;
         tnp_pkg::CTL_CHECK: begin
            ctl_in = (found || last_entry) ? tnp_pkg::CTL_IDLE : tnp_pkg::CTL_READ;
         end
         default: ctl_in = tnp_pkg::CTL_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      ptr_in = ptr_ff;
      clr_in = clr_ff;
      load   = 1'b0;
      rd_en  = 1'b0;
      tok    = '{valid: 1'b0, kind: tnp_pkg::KIND_DONE, code: 8'd0, option: '0};
      mem_wr = '{we: 1'b0, addr: ptr_ff[tnp_pkg::OptWidth-1:0],
                 refusal: tnp_pkg::REFUSAL_NONE};
      unique case (ctl_ff)
         tnp_pkg::CTL_CLEAR: begin
            mem_wr = '{we: 1'b1, addr: clr_ff, refusal: tnp_pkg::REFUSAL_NONE};
            clr_in = clr_ff + 1'b1;
         end
         tnp_pkg::CTL_IDLE: begin
            if (req_fire && req_action) begin
               // pointer past the end: nothing pending
               if (ptr_ff[tnp_pkg::OptWidth]) begin
                  load = 1'b1;
               end
            end else if (req_fire) begin
               load   = dec_token.valid;
               tok    = dec_token;
               mem_wr = dec_wr;
               if (dec_wr.we && ({1'b0, dec_wr.addr} < ptr_ff)) begin
                  ptr_in = {1'b0, dec_wr.addr};
               end
            end
         end
         tnp_pkg::CTL_READ: rd_en = 1'b1;
         tnp_pkg::CTL_CHECK: begin
            ptr_in = ptr_ff + 1'b1;
            if (found) begin
               load       = 1'b1;
               mem_wr.we  = 1'b1;   // clear the refusal being handed out
               tok.kind   = tnp_pkg::KIND_REFUSAL;
               tok.code   = (rd_data == tnp_pkg::REFUSAL_WONT) ? tnp_pkg::CODE_WONT
                                                               : tnp_pkg::CODE_DONT;
               tok.option = ptr_ff[tnp_pkg::OptWidth-1:0];
            end else if (last_entry) begin
               load = 1'b1;
            end
         end
         default: ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_option_in = rsp_option_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = tok.kind;
         rsp_code_in   = tok.code;
         rsp_option_in = tok.option;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= tnp_pkg::CTL_CLEAR;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         ptr_ff       <= ptr_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_option_ff <= rsp_option_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_code   = rsp_code_ff;
   assign rsp_option = rsp_option_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= tnp_pkg::PtrWidth'(tnp_pkg::OptCount))
      else $error("scan pointer beyond store");

   a_scan_slot_free: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == tnp_pkg::CTL_READ || ctl_ff == tnp_pkg::CTL_CHECK) |-> !rsp_valid_ff)
      else $error("output register busy during scan");

   a_check_follows_read: assert property (@(posedge clock) disable iff (reset)
      ctl_ff == tnp_pkg::CTL_CHECK |-> $past(ctl_ff) == tnp_pkg::CTL_READ)
      else $error("store data checked without a read");

   a_refusal_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == tnp_pkg::KIND_REFUSAL) |->
      (rsp_code_ff == tnp_pkg::CODE_WONT || rsp_code_ff == tnp_pkg::CODE_DONT))
      else $error("bad refusal code");

endmodule

/* sv/tnp_store.sv */
// ----------------------------------------------------------------------------
// tnp_store
// Refusal store: one entry per option, one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module tnp_store (
   input  logic                               clock,
   input  tnp_pkg::store_wr_type              wr,
   input  logic                               rd_en,
   input  logic [tnp_pkg::OptWidth-1:0]       rd_addr,
   output tnp_pkg::refusal_type               rd_data
);

   tnp_pkg::refusal_type mem [tnp_pkg::OptCount];
   tnp_pkg::refusal_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.refusal;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tnp_decode.sv */
// ----------------------------------------------------------------------------
// tnp_decode
// Byte-level telnet parser: tracks IAC sequences, emits tokens and the
// refusal to record for each negotiation.
// ----------------------------------------------------------------------------
module tnp_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   output tnp_pkg::token_type     token,
   output tnp_pkg::store_wr_type  store_wr
);

   tnp_pkg::parse_state_type state_ff;
   tnp_pkg::parse_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tnp_pkg::PARSE_DATA;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tnp_pkg::PARSE_DATA: begin
            if (data_byte == tnp_pkg::BYTE_IAC) state_in = tnp_pkg::PARSE_IAC;
         end
         tnp_pkg::PARSE_IAC: begin
            priority if (data_byte == tnp_pkg::BYTE_SE) state_in = tnp_pkg::PARSE_DATA;
            else if (data_byte >= tnp_pkg::BYTE_NOP && data_byte <= tnp_pkg::BYTE_GA)
               state_in = tnp_pkg::PARSE_DATA;
            else if (data_byte == tnp_pkg::BYTE_SB)   state_in = tnp_pkg::PARSE_SB;
            else if (data_byte == tnp_pkg::BYTE_WILL) state_in = tnp_pkg::PARSE_WILL;
            else if (data_byte == tnp_pkg::BYTE_WONT) state_in = tnp_pkg::PARSE_WONT;
            else if (data_byte == tnp_pkg::BYTE_DO)   state_in = tnp_pkg::PARSE_DO;
            else if (data_byte == tnp_pkg::BYTE_DONT) state_in = tnp_pkg::PARSE_DONT;
            else state_in = tnp_pkg::PARSE_SINK;
         end
         tnp_pkg::PARSE_SB: state_in = tnp_pkg::PARSE_SB_DATA;
         tnp_pkg::PARSE_SB_DATA: begin
            if (data_byte == tnp_pkg::BYTE_IAC) state_in = tnp_pkg::PARSE_IAC;
         end
         tnp_pkg::PARSE_DO,
         tnp_pkg::PARSE_DONT,
         tnp_pkg::PARSE_WILL,
         tnp_pkg::PARSE_WONT: state_in = tnp_pkg::PARSE_DATA;
         default: state_in = state_ff;   // sink and unused codes hold
      endcase
   end

   // outputs
   always_comb begin
      token    = '{valid: 1'b0, kind: tnp_pkg::KIND_TEXT, code: 8'd0, option: '0};
      store_wr = '{we: 1'b0, addr: data_byte, refusal: tnp_pkg::REFUSAL_NONE};
      unique case (state_ff)
         tnp_pkg::PARSE_DATA: begin
            priority if (data_byte == tnp_pkg::BYTE_IAC || data_byte == tnp_pkg::BYTE_CR) begin
               token.valid = 1'b0;
            end else if (data_byte == tnp_pkg::BYTE_LF) begin
               token.valid = 1'b1;
               token.kind  = tnp_pkg::KIND_NEWLINE;
               token.code  = tnp_pkg::BYTE_LF;
            end else begin
               token.valid = 1'b1;
               token.kind  = tnp_pkg::KIND_TEXT;
               token.code  = data_byte;
            end
         end
         tnp_pkg::PARSE_IAC: begin
            if (data_byte >= tnp_pkg::BYTE_NOP && data_byte <= tnp_pkg::BYTE_GA) begin
               token.valid = 1'b1;
               token.kind  = tnp_pkg::KIND_COMMAND;
               // report break as no-op
               token.code  = (data_byte == tnp_pkg::BYTE_BRK) ? tnp_pkg::BYTE_NOP : data_byte;
            end
         end
         tnp_pkg::PARSE_SB: begin
            token.valid  = 1'b1;
            token.kind   = tnp_pkg::KIND_SUBNEG;
            token.option = data_byte;
         end
         tnp_pkg::PARSE_DO,
         tnp_pkg::PARSE_DONT,
         tnp_pkg::PARSE_WILL,
         tnp_pkg::PARSE_WONT: begin
            token.valid  = 1'b1;
            token.kind   = tnp_pkg::KIND_NEGO;
            token.option = data_byte;
            store_wr.we  = 1'b1;
            unique case (state_ff)
               tnp_pkg::PARSE_DO:   token.code = tnp_pkg::VERB_DO;
               tnp_pkg::PARSE_DONT: token.code = tnp_pkg::VERB_DONT;
               tnp_pkg::PARSE_WILL: token.code = tnp_pkg::VERB_WILL;
               default:             token.code = tnp_pkg::VERB_WONT;
            endcase
            store_wr.refusal = (state_ff == tnp_pkg::PARSE_DO || state_ff == tnp_pkg::PARSE_DONT)
                               ? tnp_pkg::REFUSAL_WONT : tnp_pkg::REFUSAL_DONT;
         end
         default: token.valid = 1'b0;
      endcase
   end

endmodule
